/* rtl/ptbc_pkg.sv */
package ptbc_pkg;

  // Default sizing of the counter store.
  localparam int unsigned NUM_BINS_DEF   = 32;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Fixed field widths.
  localparam int unsigned TS_W        = 64;
  localparam int unsigned INTERVAL_W  = 32;
  localparam int unsigned BCOUNT_W    = 6;
  localparam int unsigned IDX_OUT_W   = 5;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OUT_FIELD_W = IDX_OUT_W + VALUE_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = INTERVAL_W;

  // Iteration counter of the divider (holds the full step count).
  localparam int unsigned DIV_STEP_W = $clog2(TS_W + 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_INTERVAL = 1'b0,
    REG_BIN_COUNT    = 1'b1
  } cfg_reg_e;

  // Request kinds carried on the input tuser.
  typedef enum logic {
    REQ_COUNT = 1'b0,
    REQ_DUMP  = 1'b1
  } req_e;

endpackage

/* rtl/ptbc_ram.sv */
module ptbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ptbc_div.sv */
module ptbc_div #(
  parameter int unsigned DEN_W = 38
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ptbc_pkg::DIV_STEP_W-1:0]     steps_i,
  input  logic [DEN_W-1:0]                    rem_i,
  input  logic [ptbc_pkg::TS_W-1:0]           num_i,
  input  logic [DEN_W-1:0]                    den_i,
  output logic                                done_o,
  output logic [ptbc_pkg::TS_W-1:0]           quot_o,
  output logic [DEN_W-1:0]                    rem_o
);

  import ptbc_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic [DEN_W-1:0]      rem_q;
  logic [DEN_W-1:0]      den_q;
  logic [TS_W-1:0]       num_q;
  logic [TS_W-1:0]       quot_q;
  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  take;

  // One restoring step: bring down the next numerator bit and try a subtract.
  always_comb begin
    trial = {rem_q, num_q[TS_W-1]};
    diff  = trial - {1'b0, den_q};
    take  = (trial >= {1'b0, den_q});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_STEP_W'(1);
        if (cnt_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, numerator shifter and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      num_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q  <= {num_q[TS_W-2:0], 1'b0};
      quot_q <= {quot_q[TS_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/pingpong_time_bin_counter_top.sv */
// Two banks of saturating event counters, split into time bins. A count item
// (tuser 0) with timestamp t adds one to bin (t mod period) / bin_interval of
// bank (t / period) mod 2, where period = bin_interval * bins in use; a dump
// item (tuser 1) streams out every bin in use of the other bank, in bin order
// with tlast on the final one, and clears each bin as it goes. A count item
// runs the 64-step timestamp division on a shared one-bit-per-cycle divider,
// a second short division for the bin (one step per bin index bit), then a
// read and a write of the counter memory. A dump item runs the bank division,
// then a read and an output state per bin, waiting while the output is
// stalled. With bin_interval zero, count items are dropped at once and a dump
// reads bank 0 without any division. Counters read as zero after reset through
// per-entry valid flags, so no clearing pass is needed.
module pingpong_time_bin_counter_top #(
  parameter int unsigned NUM_BINS   = ptbc_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_BITS = ptbc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ptbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ptbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ptbc_pkg::TS_W-1:0]         s_axis_tdata,  // [63:0] timestamp
  input  logic [0:0]                        s_axis_tuser,  // [0] req_type
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ptbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [4:0] bin_index,
                                                           // [36:5] bin_count_value
  output logic                              m_axis_tlast
);

  import ptbc_pkg::*;

  localparam int unsigned NB_W     = $clog2(NUM_BINS + 1);
  localparam int unsigned BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned PERIOD_W = INTERVAL_W + NB_W;
  localparam int unsigned DEPTH    = 2 * NUM_BINS;
  localparam int unsigned AW       = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_BANK,
    S_DIV_BIN,
    S_EV_WB,
    S_DP_RD,
    S_DP_OUT
  } state_e;

  state_e                  state_q;
  req_e                    req_q;
  logic                    bank_q;
  logic [BIN_W-1:0]        idx_q;
  logic [AW-1:0]           addr_q;
  logic [DEPTH-1:0]        valid_q;
  logic                    rd_valid_q;
  logic [INTERVAL_W-1:0]   bin_interval_q;
  logic [BCOUNT_W-1:0]     bin_count_q;
  logic                    out_valid_q;
  logic [IDX_OUT_W-1:0]    out_idx_q;
  logic [VALUE_W-1:0]      out_val_q;
  logic                    out_last_q;

  logic [NB_W-1:0]         n_bins;
  logic [PERIOD_W-1:0]     period;
  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  logic                    div_start;
  logic [DIV_STEP_W-1:0]   div_steps;
  logic [PERIOD_W-1:0]     div_rem_in;
  logic [TS_W-1:0]         div_num;
  logic [PERIOD_W-1:0]     div_den;
  logic                    div_done;
  logic [TS_W-1:0]         div_quot;
  logic [PERIOD_W-1:0]     div_rem;
  logic [BIN_W-1:0]        bin;
  logic                    bin_ok;
  logic                    ram_re;
  logic [AW-1:0]           rd_addr;
  logic                    ram_we;
  logic [COUNT_BITS-1:0]   ram_wdata;
  logic [COUNT_BITS-1:0]   ram_rdata;
  logic [COUNT_BITS-1:0]   rd_cnt;
  logic                    dump_last;

  // Entry of bank b, bin i sits at b * NUM_BINS + i.
  function automatic logic [AW-1:0] mk_addr(logic b, logic [BIN_W-1:0] i);
    mk_addr = b ? (AW'(NUM_BINS) + AW'(i)) : AW'(i);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_interval_q <= '0;
      bin_count_q    <= BCOUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BIN_INTERVAL: bin_interval_q <= cfg_data_i;
        REG_BIN_COUNT:    bin_count_q    <= cfg_data_i[BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bins in use and the period that they span.
  always_comb begin
    if (7'(bin_count_q) > 7'(NUM_BINS)) begin
      n_bins = NB_W'(NUM_BINS);
    end else begin
      n_bins = NB_W'(bin_count_q);
    end
    period = PERIOD_W'(bin_interval_q) * PERIOD_W'(n_bins);
  end

  // Handshakes, divider operands and memory accesses.
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    in_acc        = s_axis_tvalid && s_axis_tready;
    out_free      = !out_valid_q || m_axis_tready;
    out_load      = (state_q == S_DP_OUT) && out_free;

    // The bank division runs t / period; the bin division runs
    // rem / bin_interval over only the low bits, its quotient being below NUM_BINS.
    if (state_q == S_DIV_BANK) begin
      div_steps  = DIV_STEP_W'(BIN_W);
      div_rem_in = PERIOD_W'(div_rem >> BIN_W);
      div_num    = TS_W'(div_rem[BIN_W-1:0]) << (TS_W - BIN_W);
      div_den    = PERIOD_W'(bin_interval_q);
    end else begin
      div_steps  = DIV_STEP_W'(TS_W);
      div_rem_in = '0;
      div_num    = s_axis_tdata;
      div_den    = period;
    end
    div_start = (in_acc && (period != '0)) ||
                ((state_q == S_DIV_BANK) && div_done && (req_q == REQ_COUNT));

    bin    = div_quot[BIN_W-1:0];
    bin_ok = (NB_W'(bin) < n_bins);

    ram_re  = 1'b0;
    rd_addr = mk_addr(bank_q, idx_q);
    if ((state_q == S_DIV_BIN) && div_done && bin_ok) begin
      ram_re  = 1'b1;
      rd_addr = mk_addr(bank_q, bin);
    end else if (state_q == S_DP_RD) begin
      ram_re = 1'b1;
    end

    rd_cnt    = rd_valid_q ? ram_rdata : '0;
    ram_we    = (state_q == S_EV_WB);
    ram_wdata = (rd_cnt == '1) ? rd_cnt : (rd_cnt + COUNT_BITS'(1));
    dump_last = ((NB_W'(idx_q) + NB_W'(1)) == n_bins);
  end

  // Sequencer, valid flags and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_COUNT;
      bank_q      <= 1'b0;
      idx_q       <= '0;
      addr_q      <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // A result stays valid until the sink takes it or a new one replaces it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q <= req_e'(s_axis_tuser);
            if (period != '0) begin
              state_q <= S_DIV_BANK;
            end else if ((req_e'(s_axis_tuser) == REQ_DUMP) && (n_bins != '0)) begin
              bank_q  <= 1'b0;
              idx_q   <= '0;
              state_q <= S_DP_RD;
            end
          end
        end
        S_DIV_BANK: begin
          if (div_done) begin
            if (req_q == REQ_COUNT) begin
              bank_q  <= div_quot[0];
              state_q <= S_DIV_BIN;
            end else begin
              bank_q  <= ~div_quot[0];
              idx_q   <= '0;
              state_q <= S_DP_RD;
            end
          end
        end
        S_DIV_BIN: begin
          if (div_done) begin
            addr_q  <= rd_addr;
            state_q <= bin_ok ? S_EV_WB : S_IDLE;
          end
        end
        S_EV_WB: begin
          valid_q[addr_q] <= 1'b1;
          state_q         <= S_IDLE;
        end
        S_DP_RD: begin
          addr_q  <= rd_addr;
          state_q <= S_DP_OUT;
        end
        S_DP_OUT: begin
          if (out_free) begin
            out_idx_q       <= IDX_OUT_W'(idx_q);
            out_val_q       <= VALUE_W'(rd_cnt);
            out_last_q      <= dump_last;
            valid_q[addr_q] <= 1'b0;
            if (dump_last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + BIN_W'(1);
              state_q <= S_DP_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Shared iterative divider.
  ptbc_div #(
    .DEN_W (PERIOD_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .steps_i (div_steps),
    .rem_i   (div_rem_in),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Counter store for both banks.
  ptbc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_val_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/ptbc_checker.sv */
module ptbc_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ptbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ptbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [ptbc_pkg::TS_W-1:0]         s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [ptbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              m_axis_tlast
);

  import ptbc_pkg::*;

  logic [IDX_OUT_W-1:0] exp_idx_q;
  logic [IDX_OUT_W-1:0] exp_idx_d;

  // Expected bin of the next result: a dump starts at bin zero and counts up.
  always_comb begin
    exp_idx_d = exp_idx_q;
    if (m_axis_tvalid && m_axis_tready) begin
      exp_idx_d = m_axis_tlast ? '0 : (exp_idx_q + IDX_OUT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else begin
      exp_idx_q <= exp_idx_d;
    end
  end

  // A stalled result holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Results of one dump come in bin order from zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[IDX_OUT_W-1:0] == exp_idx_q))
    else $error("result out of bin order");

  // No new item is taken while a dump is still streaming.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("item accepted in the middle of a dump");

  // A count item produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_COUNT)
      |=> !$rose(m_axis_tvalid))
    else $error("result raised after a count item");

endmodule

bind pingpong_time_bin_counter_top ptbc_checker u_ptbc_checker (.*);

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptbc_pkg::*;

  localparam int unsigned NB            = NUM_BINS_DEF;
  // A count item may still be in flight when the last dump result arrives,
  // so allow for its whole run before touching registers.
  localparam int unsigned SETTLE_CYCLES = 160;

  // One reported bin as it appears on the result stream.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [VALUE_W-1:0]   count;
    logic                 last;
  } bin_report_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TS_W-1:0]        s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Shadow copy of the block: registers and both counter banks.
  logic [INTERVAL_W-1:0]  bin_interval_q = '0;
  logic [BCOUNT_W-1:0]    bin_count_q    = BCOUNT_W'(1);
  logic [VALUE_W-1:0]     bank_cnt [2*NB];
  bin_report_t            pending_bins [$];

  // Run bookkeeping.
  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned dumps_sent      = 0;
  int unsigned reports_checked = 0;
  int unsigned settings_used   = 0;
  int unsigned idle_odds       = 4;
  bit          calm            = 1'b0;
  bit          in_flight       = 1'b0;
  int unsigned stall_left      = 0;

  pingpong_time_bin_counter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d bin reports still outstanding.", pending_bins.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < 2 * NB; i++) begin
      bank_cnt[i] = '0;
    end
  end

  // Updates the shadow banks for one accepted item and queues the bins a dump
  // will report, oldest first.
  function automatic void tally_item(req_e kind, logic [TS_W-1:0] ts);
    logic [63:0] nbins;
    logic [63:0] period;
    logic [63:0] quo;
    logic [63:0] bin;
    logic        bank;
    int unsigned slot;
    bin_report_t rep;
    nbins  = (bin_count_q > NB) ? 64'(NB) : 64'(bin_count_q);
    period = 64'(bin_interval_q) * nbins;
    if (kind == REQ_COUNT) begin
      // Dropped while unconfigured or with no bins in use.
      if (period == 0) return;
      quo  = ts / period;
      bank = quo[0];
      bin  = (ts % period) / 64'(bin_interval_q);
      if (bin < nbins) begin
        slot = (bank ? NB : 0) + int'(bin);
        if (bank_cnt[slot] != {VALUE_W{1'b1}}) bank_cnt[slot] = bank_cnt[slot] + 1'b1;
      end
    end else begin
      // Unconfigured dumps always read bank 0; otherwise the idle bank.
      if (period == 0) begin
        bank = 1'b0;
      end else begin
        quo  = ts / period + 64'd1;
        bank = quo[0];
      end
      for (int unsigned i = 0; i < nbins; i++) begin
        slot      = (bank ? NB : 0) + i;
        rep.index = IDX_OUT_W'(i);
        rep.count = bank_cnt[slot];
        rep.last  = (64'(i) + 64'd1 == nbins);
        pending_bins.push_back(rep);
        bank_cnt[slot] = '0;
      end
    end
  endfunction

  // Result side: compare each accepted bin report and stall in random bursts.
  always @(posedge clk_i) begin : bin_checker
    bin_report_t got;
    bin_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.index = m_axis_tdata[IDX_OUT_W-1:0];
      got.count = m_axis_tdata[IDX_OUT_W +: VALUE_W];
      got.last  = m_axis_tlast;
      reports_checked++;
      if (pending_bins.size() == 0) begin
        $error("Unexpected bin report: bin_index %0d, bin_count_value %0d, last %0b",
               got.index, got.count, got.last);
        mismatches++;
      end else begin
        want = pending_bins.pop_front();
        if (got.index != want.index) begin
          $error("bin_index mismatch: expected %0d, got %0d", want.index, got.index);
          mismatches++;
        end
        if (got.count != want.count) begin
          $error("bin_count_value mismatch: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
        if (got.last != want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, got.last);
          mismatches++;
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (calm || idle_odds == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, idle_odds - 1) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Drops tvalid after the last accepted item and lets a clock edge pass.
  task automatic halt_input();
    if (in_flight) begin
      s_axis_tvalid <= 1'b0;
      in_flight = 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Sends one item, possibly after a random gap, and predicts its effect.
  task automatic push_item(req_e kind, logic [TS_W-1:0] ts);
    int unsigned gap;
    gap = 0;
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap != 0) begin
      halt_input();
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    s_axis_tuser  <= kind;
    in_flight = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tally_item(kind, ts);
    items_sent++;
    if (kind == REQ_DUMP) dumps_sent++;
  endtask

  // Waits for every queued bin report, then for any count still in progress.
  task automatic drain_and_settle();
    halt_input();
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (which)
      REG_BIN_INTERVAL: bin_interval_q = value;
      REG_BIN_COUNT:    bin_count_q    = value[BCOUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic configure(logic [INTERVAL_W-1:0] interval, logic [BCOUNT_W-1:0] count);
    drain_and_settle();
    write_reg(REG_BIN_INTERVAL, interval);
    write_reg(REG_BIN_COUNT, CFG_DATA_W'(count));
    settings_used++;
  endtask

  // Out of reset nothing is configured: counts are dropped, dumps read bank 0.
  task automatic test_unconfigured();
    push_item(REQ_COUNT, 64'd0);
    push_item(REQ_COUNT, {TS_W{1'b1}});
    push_item(REQ_DUMP, 64'd5);
    configure(32'd0, 6'd32);
    push_item(REQ_COUNT, 64'd123);
    push_item(REQ_DUMP, {TS_W{1'b1}});
  endtask

  // Events on both sides of the first bin edge and the first bank edge with a 40-unit period.
  task automatic test_bin_edges();
    configure(32'd10, 6'd4);
    push_item(REQ_COUNT, 64'd0);
    push_item(REQ_COUNT, 64'd9);
    push_item(REQ_COUNT, 64'd10);
    push_item(REQ_COUNT, 64'd39);
    push_item(REQ_COUNT, 64'd40);
    push_item(REQ_COUNT, 64'd79);
    push_item(REQ_COUNT, {TS_W{1'b1}});
    push_item(REQ_DUMP, 64'd0);
    push_item(REQ_DUMP, 64'd40);
    push_item(REQ_DUMP, {TS_W{1'b1}});
  endtask

  // Widest interval with an oversized bin count, then unconfigured with
  // counts left in bank 0, then no bins in use at all.
  task automatic test_size_extremes();
    configure(32'hFFFF_FFFF, 6'd63);
    push_item(REQ_COUNT, 64'd0);
    push_item(REQ_COUNT, 64'h0000_0000_FFFF_FFFF);
    push_item(REQ_COUNT, {TS_W{1'b1}});
    push_item(REQ_DUMP, 64'd0);
    configure(32'd0, 6'd33);
    push_item(REQ_DUMP, 64'd77);
    configure(32'd7, 6'd0);
    push_item(REQ_COUNT, 64'd5);
    push_item(REQ_DUMP, 64'd5);
  endtask

  // Mostly events that walk forward in time, with some scattered anywhere,
  // and a dump about every sixth item.
  task automatic random_phase(logic [INTERVAL_W-1:0] interval, logic [BCOUNT_W-1:0] count,
                              int unsigned n_items, int unsigned odds);
    logic [TS_W-1:0]       t_now;
    logic [TS_W-1:0]       ts;
    logic [INTERVAL_W-1:0] hop;
    req_e                  kind;
    configure(interval, count);
    idle_odds = odds;
    t_now = {$urandom, $urandom};
    hop   = (interval == 0) ? 32'hFFFF_FFFF : interval;
    for (int unsigned k = 0; k < n_items; k++) begin
      kind = ($urandom_range(0, 5) == 0) ? REQ_DUMP : REQ_COUNT;
      if ($urandom_range(0, 2) == 0) begin
        ts = {$urandom, $urandom};
      end else begin
        t_now = t_now + 64'($urandom_range(0, hop));
        ts    = t_now;
      end
      push_item(kind, ts);
      // Let the result stream run dry once in the middle of every phase.
      if (k == n_items / 2) begin
        halt_input();
        while (pending_bins.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  task automatic test_random();
    random_phase(32'd10, 6'd4, 75, 4);
    random_phase(32'd1, 6'd32, 75, 3);
    random_phase($urandom, 6'($urandom_range(1, 32)), 75, 5);
    random_phase(32'hFFFF_FFFF, 6'd63, 75, 0);
    random_phase(32'($urandom_range(1, 1000)), 6'd0, 30, 6);
    random_phase(32'd0, 6'($urandom_range(1, 32)), 30, 4);
    random_phase(32'($urandom_range(1, 50)), 6'($urandom_range(33, 63)), 75, 3);
    // Final stretch at full rate on both sides.
    calm = 1'b1;
    random_phase(32'($urandom_range(1, 20)), 6'($urandom_range(1, 32)), 75, 0);
  endtask

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    test_unconfigured();
    test_bin_edges();
    test_size_extremes();
    test_random();
    drain_and_settle();
    $display("Covered %0d items (%0d dumps) over %0d register settings; %0d bin reports checked.",
             items_sent, dumps_sent, settings_used, reports_checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
